// ----- rtl/range_list_text_to_bitmap_unit_defines.svh -----
// assertion macros for the range list text to bitmap unit
// used by the top level only, depends on nothing else
`ifndef RANGE_LIST_TEXT_TO_BITMAP_UNIT_DEFINES_SVH
`define RANGE_LIST_TEXT_TO_BITMAP_UNIT_DEFINES_SVH

// same-cycle implication, checked out of reset
`define RLTB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define RLTB_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/rltb_pkg.sv -----
// shared types, constants and character helpers for the range list unit
// no dependencies
package rltb_pkg;

	localparam logic [7:0] CharZero  = 8'h30;
	localparam logic [7:0] CharNine  = 8'h39;
	localparam logic [7:0] CharDash  = 8'h2d;
	localparam logic [7:0] CharComma = 8'h2c;
	localparam logic [7:0] CharSpace = 8'h20;
	localparam logic [7:0] CharTab   = 8'h09;
	localparam logic [7:0] CharCr    = 8'h0d;
	localparam logic [7:0] CharA     = 8'h61;
	localparam logic [7:0] CharL     = 8'h6c;
	localparam logic [7:0] CharN     = 8'h6e;
	localparam logic [7:0] CharO     = 8'h6f;
	localparam logic [7:0] CharE     = 8'h65;

	localparam logic [31:0] Mask16 = 32'h0000_ffff;
	localparam logic [31:0] Mask32 = 32'hffff_ffff;

	typedef struct packed {
		logic [7:0] text_char;
		logic       is_last;
	} item_t;

	typedef struct packed {
		logic [31:0] bitmap;
		logic        out_of_range;
		logic        keyword_hit;
	} result_t;

	// one character step handed to the state units
	typedef struct packed {
		logic       fire;
		logic       last;
		logic [7:0] ch;
	} step_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CharSpace) || ((c >= CharTab) && (c <= CharCr));
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CharZero) && (c <= CharNine);
	endfunction

endpackage

// ----- rtl/rltb_kw.sv -----
// keyword matcher for the texts all and none
// depends on rltb_pkg
module rltb_kw
	import rltb_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  step_t step,
	output logic  kw_all,
	output logic  kw_none
);

	typedef enum logic [8:0] {
		KW_START = 9'b000000001,
		KW_A     = 9'b000000010,
		KW_AL    = 9'b000000100,
		KW_ALL   = 9'b000001000,
		KW_N     = 9'b000010000,
		KW_NO    = 9'b000100000,
		KW_NON   = 9'b001000000,
		KW_NONE  = 9'b010000000,
		KW_FAIL  = 9'b100000000
	} kw_state_t;

	kw_state_t state_q;
	kw_state_t state_d;
	logic      sp;

	always_comb begin
		sp = is_space(step.ch);
		case (state_q)
			KW_START: begin
				if (sp) state_d = KW_START;
				else if (step.ch == CharA) state_d = KW_A;
				else if (step.ch == CharN) state_d = KW_N;
				else state_d = KW_FAIL;
			end
			KW_A:    state_d = (step.ch == CharL) ? KW_AL : KW_FAIL;
			KW_AL:   state_d = (step.ch == CharL) ? KW_ALL : KW_FAIL;
			KW_ALL:  state_d = sp ? KW_ALL : KW_FAIL;
			KW_N:    state_d = (step.ch == CharO) ? KW_NO : KW_FAIL;
			KW_NO:   state_d = (step.ch == CharN) ? KW_NON : KW_FAIL;
			KW_NON:  state_d = (step.ch == CharE) ? KW_NONE : KW_FAIL;
			KW_NONE: state_d = sp ? KW_NONE : KW_FAIL;
			default: state_d = KW_FAIL;
		endcase
	end

	assign kw_all  = (state_d == KW_ALL);
	assign kw_none = (state_d == KW_NONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= KW_START;
		end else if (step.fire) begin
			state_q <= step.last ? KW_START : state_d;
		end
	end

endmodule

// ----- rtl/rltb_acc.sv -----
// number, range and channel mask accumulator
// depends on rltb_pkg
module rltb_acc
	import rltb_pkg::*;
#(
	parameter int MAX_WIDTH = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  step_t                step,
	output logic [MAX_WIDTH-1:0] mask,
	output logic                 ovf
);

	localparam logic [7:0] MaxNum = 8'(MAX_WIDTH);

	logic [7:0]           number_acc_q;
	logic [7:0]           range_start_q;
	logic                 in_range_q;
	logic [MAX_WIDTH-1:0] mask_q;
	logic                 ovf_q;

	logic                 digit;
	logic                 sep;
	logic                 dash;
	logic [11:0]          prod;
	logic [7:0]           num_d;
	logic [7:0]           start_d;
	logic                 in_range_d;
	logic [7:0]           lo;
	logic                 commit;
	logic [MAX_WIDTH-1:0] span;
	logic [MAX_WIDTH-1:0] mask_d;
	logic                 ovf_d;

	always_comb begin
		digit = is_digit(step.ch);
		sep   = is_space(step.ch) || (step.ch == CharComma);
		dash  = (step.ch == CharDash);
		// times ten as two shifted adds, then the digit
		prod  = {1'b0, number_acc_q, 3'b000} + {3'b000, number_acc_q, 1'b0}
			+ {4'h0, step.ch - CharZero};

		num_d      = number_acc_q;
		start_d    = range_start_q;
		in_range_d = in_range_q;
		if (digit) begin
			num_d = (prod > 12'd255) ? 8'd255 : prod[7:0];
		end else if (dash) begin
			in_range_d = 1'b1;
			start_d    = number_acc_q;
			num_d      = 8'd0;
		end

		// a single channel is the range n..n; numbers above the top select no lane
		lo     = in_range_d ? start_d : num_d;
		commit = (sep || step.last) && (num_d != 8'd0);
		for (int i = 0; i < MAX_WIDTH; i++) begin
			span[i] = (lo <= 8'(i + 1)) && (num_d >= 8'(i + 1));
		end

		mask_d = mask_q;
		ovf_d  = ovf_q;
		if (commit) begin
			mask_d = mask_q | span;
			if ((num_d > MaxNum) || (in_range_d && (start_d > MaxNum))) begin
				ovf_d = 1'b1;
			end
		end
		if (sep || step.last) begin
			in_range_d = 1'b0;
			num_d      = 8'd0;
		end
	end

	assign mask = mask_d;
	assign ovf  = ovf_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_acc_q  <= '0;
			range_start_q <= '0;
			in_range_q    <= 1'b0;
			mask_q        <= '0;
			ovf_q         <= 1'b0;
		end else if (step.fire) begin
			if (step.last) begin
				number_acc_q  <= '0;
				range_start_q <= '0;
				in_range_q    <= 1'b0;
				mask_q        <= '0;
				ovf_q         <= 1'b0;
			end else begin
				number_acc_q  <= num_d;
				range_start_q <= start_d;
				in_range_q    <= in_range_d;
				mask_q        <= mask_d;
				ovf_q         <= ovf_d;
			end
		end
	end

endmodule

// ----- rtl/range_list_text_to_bitmap_unit.sv -----
// top level of the range list text to bitmap unit
// depends on rltb_pkg, rltb_kw, rltb_acc and the assertion macro header
//
// Takes a channel list text such as "1-4 6,9" one character per beat and
// returns one bitmap beat for the character marked is_last; bit n-1 stands
// for channel n. Digits build a number (saturating at 255), a dash opens a
// range, and a space, tab, LF, VT, FF, CR, comma or the end of the text
// commits it. A text that trims to "all" or "none" gives the mode's all-ones
// value or zero with keyword_hit set. cfg_wdata written with cfg_we selects a
// 16-bit (0) or 32-bit (1) bitmap; write it only while no text is in flight.
// Throughput is one character per clock: each character is registered, then
// updated in one pass through the keyword matcher and the accumulator, whose
// mask is formed by one compare pair per channel lane. The result is registered
// when the last character moves on from the input register. Only a last character
// waits, and only while the previous result has not yet been taken.
`include "range_list_text_to_bitmap_unit_defines.svh"

module range_list_text_to_bitmap_unit
	import rltb_pkg::*;
#(
	parameter int MAX_WIDTH = 32
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_we,
	input  logic    cfg_wdata,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	// configuration
	logic wide_mode_q;

	// input stage
	logic  valid_s1;
	item_t item_s1;
	logic  advance;
	step_t step;

	// state unit results
	logic                 kw_all;
	logic                 kw_none;
	logic [MAX_WIDTH-1:0] acc_mask;
	logic                 acc_ovf;

	// result register
	logic    result_valid_q;
	result_t result_q;
	logic [31:0] width_mask;
	result_t     result_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_mode_q <= 1'b0;
		end else if (cfg_we) begin
			wide_mode_q <= cfg_wdata;
		end
	end

	// a registered character moves on unless it is the last and the result slot is full and not being taken
	assign advance    = valid_s1 && (!item_s1.is_last || !result_valid_q || result_ready);
	assign item_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	// payload only, no reset needed
	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	assign step.fire = advance;
	assign step.last = item_s1.is_last;
	assign step.ch   = item_s1.text_char;

	rltb_kw u_kw (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.kw_all  (kw_all),
		.kw_none (kw_none)
	);

	rltb_acc #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_acc (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.mask   (acc_mask),
		.ovf    (acc_ovf)
	);

	// final beat: keywords override the committed mask and clear the flag
	always_comb begin
		width_mask = wide_mode_q ? Mask32 : Mask16;
		result_d.keyword_hit  = kw_all || kw_none;
		result_d.out_of_range = acc_ovf && !(kw_all || kw_none);
		if (kw_all) begin
			result_d.bitmap = width_mask;
		end else if (kw_none) begin
			result_d.bitmap = '0;
		end else begin
			result_d.bitmap = 32'(acc_mask) & width_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && item_s1.is_last) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.is_last) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	// a last character that moves on always leaves a result beat behind
	`RLTB_ASSERT_NXT(a_last_gives_result, clk, arst_n, advance && item_s1.is_last,
		result_valid_q, "last character produced no result")
	// keyword results never carry the range flag
	`RLTB_ASSERT_NOW(a_kw_no_ovf, clk, arst_n, result_valid_q && result_q.keyword_hit,
		!result_q.out_of_range, "keyword result with out_of_range set")
	// narrow mode keeps the upper half clear
	`RLTB_ASSERT_NOW(a_narrow_upper_zero, clk, arst_n, result_valid_q && !wide_mode_q,
		result_q.bitmap[31:16] == 16'h0000, "upper bitmap bits set in narrow mode")

endmodule

// ----- dv/range_list_bitmap_check.sv -----
`timescale 1ns / 1ps
// scoreboard for the range list text to bitmap unit: folds each accepted character
// into its own copy of the list state and compares every bitmap beat field by field
// depends on rltb_pkg only
module range_list_bitmap_check
	import rltb_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    cfg_we,
	input  logic    cfg_wdata,
	input  logic    item_valid,
	input  logic    item_ready,
	input  item_t   item,
	input  logic    result_valid,
	input  logic    result_ready,
	input  result_t result,
	output int      waiting,
	output int      mismatches,
	output int      bitmaps_seen
);
	localparam int ChanMax = 32;
	localparam int AccCeil = 255;

	typedef enum logic [3:0] {
		KwStart = 4'd0,
		KwA     = 4'd1,
		KwAl    = 4'd2,
		KwAll   = 4'd3,
		KwN     = 4'd4,
		KwNo    = 4'd5,
		KwNon   = 4'd6,
		KwNone  = 4'd7,
		KwFail  = 4'd15
	} kw_t;

	logic        wide_mode;
	logic [7:0]  number_acc;
	logic [7:0]  range_start;
	logic        in_range;
	logic [31:0] chan_mask;
	kw_t         kw_state;
	logic        overflow_seen;
	result_t     expected_bitmaps[$];
	int          fail_n;
	int          seen_n;

	function automatic logic is_blank(logic [7:0] c);
		return c inside {CharSpace, [CharTab:CharCr]};
	endfunction

	function automatic kw_t kw_next(kw_t k, logic [7:0] c);
		case (k)
			KwStart: begin
				if (is_blank(c)) return KwStart;
				if (c == CharA) return KwA;
				if (c == CharN) return KwN;
				return KwFail;
			end
			KwAll, KwNone: return is_blank(c) ? k : KwFail;
			KwA:           return (c == CharL) ? KwAl : KwFail;
			KwAl:          return (c == CharL) ? KwAll : KwFail;
			KwN:           return (c == CharO) ? KwNo : KwFail;
			KwNo:          return (c == CharN) ? KwNon : KwFail;
			KwNon:         return (c == CharE) ? KwNone : KwFail;
			default:       return KwFail;
		endcase
	endfunction

	// channels lo..hi inclusive, 1-based, hi clipped to the widest bitmap
	function automatic logic [31:0] span_bits(int lo, int hi);
		logic [63:0] upper;
		logic [63:0] lower;
		if (lo < 1) lo = 1;
		if (hi > ChanMax) hi = ChanMax;
		if (lo > hi) return '0;
		upper = (64'd1 << hi) - 64'd1;
		lower = (64'd1 << (lo - 1)) - 64'd1;
		return 32'(upper & ~lower);
	endfunction

	function automatic void commit_number();
		if (number_acc != 8'd0) begin
			if (number_acc > ChanMax) overflow_seen = 1'b1;
			if (in_range) begin
				if (range_start > ChanMax) overflow_seen = 1'b1;
				chan_mask |= span_bits(range_start, number_acc);
			end else if (number_acc <= ChanMax) begin
				chan_mask |= span_bits(number_acc, number_acc);
			end
		end
		in_range = 1'b0;
		number_acc = 8'd0;
	endfunction

	function automatic void clear_text();
		number_acc = 8'd0;
		range_start = 8'd0;
		in_range = 1'b0;
		chan_mask = '0;
		kw_state = KwStart;
		overflow_seen = 1'b0;
	endfunction

	// returns 1 with the bitmap beat when the character ends the text
	function automatic bit fold_char(item_t it, output result_t r);
		int          v;
		logic [31:0] width_mask;
		r = '0;
		kw_state = kw_next(kw_state, it.text_char);
		if (it.text_char >= CharZero && it.text_char <= CharNine) begin
			v = int'(number_acc) * 10 + int'(it.text_char - CharZero);
			number_acc = (v > AccCeil) ? 8'(AccCeil) : 8'(v);
		end else if (it.text_char == CharComma || is_blank(it.text_char)) begin
			commit_number();
		end else if (it.text_char == CharDash) begin
			in_range = 1'b1;
			range_start = number_acc;
			number_acc = 8'd0;
		end
		if (!it.is_last) return 1'b0;
		commit_number();
		width_mask = wide_mode ? Mask32 : Mask16;
		if (kw_state == KwAll) begin
			r.bitmap = width_mask;
			r.keyword_hit = 1'b1;
		end else if (kw_state == KwNone) begin
			r.keyword_hit = 1'b1;
		end else begin
			r.bitmap = chan_mask & width_mask;
			r.out_of_range = overflow_seen;
		end
		clear_text();
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		result_t next_r;
		if (!arst_n) begin
			wide_mode = 1'b0;
			clear_text();
			expected_bitmaps.delete();
			fail_n = 0;
			seen_n = 0;
		end else begin
			if (cfg_we) wide_mode = cfg_wdata;
			// outgoing beat first: it belongs to a text whose last character was taken earlier
			if (result_valid && result_ready) begin
				seen_n++;
				if (expected_bitmaps.size() == 0) begin
					$display("%0t: unexpected bitmap beat, expected none, got %h/%b/%b",
						$time, result.bitmap, result.out_of_range, result.keyword_hit);
					fail_n++;
				end else begin
					want = expected_bitmaps.pop_front();
					if (result.bitmap !== want.bitmap) begin
						$display("%0t: bitmap mismatch, expected %h, got %h",
							$time, want.bitmap, result.bitmap);
						fail_n++;
					end
					if (result.out_of_range !== want.out_of_range) begin
						$display("%0t: out_of_range mismatch, expected %b, got %b",
							$time, want.out_of_range, result.out_of_range);
						fail_n++;
					end
					if (result.keyword_hit !== want.keyword_hit) begin
						$display("%0t: keyword_hit mismatch, expected %b, got %b",
							$time, want.keyword_hit, result.keyword_hit);
						fail_n++;
					end
				end
			end
			if (item_valid && item_ready) begin
				if (fold_char(item, next_r)) expected_bitmaps.push_back(next_r);
			end
		end
		waiting <= expected_bitmaps.size();
		mismatches <= fail_n;
		bitmaps_seen <= seen_n;
	end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// testbench top for the range list text to bitmap unit: sends channel list texts
// one character per beat, switches the bitmap width between phases, gives the verdict
// depends on rltb_pkg, range_list_text_to_bitmap_unit and range_list_bitmap_check
module tb;
	import rltb_pkg::*;

	// blank characters besides space, tab and cr
	localparam logic [7:0] CharLf = 8'h0a;
	localparam logic [7:0] CharVt = 8'h0b;
	localparam logic [7:0] CharFf = 8'h0c;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    cfg_we = 1'b0;
	logic    cfg_wdata = 1'b0;
	logic    item_valid = 1'b0;
	logic    item_ready;
	item_t   item = '0;
	logic    result_valid;
	logic    result_ready = 1'b0;
	result_t result;

	// from the scoreboard
	int waiting;
	int mismatches;
	int bitmaps_seen;

	// idle policy, percent of cycles, changed per phase
	int send_idle_pct = 12;
	int recv_idle_pct = 50;

	int         texts_sent = 0;
	int         chars_sent = 0;
	logic [7:0] text_q[$];
	int         ignored_n;

	range_list_text_to_bitmap_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	range_list_bitmap_check scoreboard (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.waiting      (waiting),
		.mismatches   (mismatches),
		.bitmaps_seen (bitmaps_seen)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// receiver: random stalls at the phase's idle rate
	always @(posedge clk) begin
		result_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// blank or separator character; comma is a separator but not a blank
	function automatic logic [7:0] sep_char(bit blank_only);
		case ($urandom_range(blank_only ? 5 : 6))
			0:       return CharSpace;
			1:       return CharTab;
			2:       return CharLf;
			3:       return CharVt;
			4:       return CharFf;
			5:       return CharCr;
			default: return CharComma;
		endcase
	endfunction

	function automatic void push_string(string s);
		foreach (s[i]) text_q.push_back(s[i]);
	endfunction

	function automatic void add_seps(bit blank_only);
		repeat ($urandom_range(2, 1)) text_q.push_back(sep_char(blank_only));
	endfunction

	// arbitrary byte; mostly ignored by the unit, so not counted as real work
	function automatic void add_noise();
		text_q.push_back(8'($urandom_range(255)));
		ignored_n++;
	endfunction

	// channel numbers: mostly in range, some zero, some past 32, some past 255
	function automatic int pick_number();
		int r;
		r = $urandom_range(99);
		if (r < 80) return $urandom_range(32, 1);
		if (r < 88) return 0;
		if (r < 95) return $urandom_range(60, 33);
		return $urandom_range(999, 61);
	endfunction

	function automatic void add_number(int n);
		// a leading zero now and then must not change the value
		if ($urandom_range(9) == 0) text_q.push_back(CharZero);
		push_string($sformatf("%0d", n));
	endfunction

	// well-formed list with random content, plus dangling and doubled dashes
	function automatic void build_list();
		int lo;
		int r;
		if ($urandom_range(99) < 15) add_seps(1'b0);
		for (int t = 0; t < $urandom_range(5, 1); t++) begin
			// a missing separator merges two numbers, which is legal text too
			if (t > 0 && $urandom_range(99) >= 5) add_seps(1'b0);
			lo = pick_number();
			r = $urandom_range(99);
			if (r < 45) begin
				add_number(lo);
			end else if (r < 85) begin
				add_number(lo);
				text_q.push_back(CharDash);
				add_number(($urandom_range(99) < 60) ? lo + $urandom_range(10) : pick_number());
			end else if (r < 90) begin
				// range with no start
				text_q.push_back(CharDash);
				add_number(lo);
			end else if (r < 95) begin
				// second dash replaces the start
				add_number(lo);
				text_q.push_back(CharDash);
				add_number(pick_number());
				text_q.push_back(CharDash);
				add_number(pick_number());
			end else begin
				// dash with nothing after it
				add_number(lo);
				text_q.push_back(CharDash);
			end
			if ($urandom_range(99) < 5) add_noise();
		end
		if ($urandom_range(99) < 25) add_seps(1'b0);
	endfunction

	// keyword texts, exact ones with blank padding and near misses
	function automatic void build_keyword();
		string forms[10] = '{"all", "none", "al", "non", "nonee", "alll", "All", "n0ne",
			"a ll", "allx"};
		if ($urandom_range(1)) add_seps(1'b1);
		if ($urandom_range(99) < 60) push_string(forms[$urandom_range(1)]);
		else push_string(forms[$urandom_range(9)]);
		if ($urandom_range(1)) add_seps($urandom_range(99) < 85);
		if ($urandom_range(99) < 10) add_number(pick_number());
	endfunction

	function automatic void make_text();
		int r;
		text_q.delete();
		ignored_n = 0;
		r = $urandom_range(99);
		if (r < 12) begin
			build_keyword();
		end else if (r < 17) begin
			repeat ($urandom_range(6, 1)) add_noise();
		end else begin
			build_list();
		end
	endfunction

	// one character beat; valid stays up until the unit takes it
	task automatic send_char(logic [7:0] c, logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{text_char: c, is_last: last};
		@(posedge clk);
		while (!item_ready) @(posedge clk);
		chars_sent++;
	endtask

	task automatic send_text();
		foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
		texts_sent++;
	endtask

	task automatic send_string(string s);
		text_q.delete();
		push_string(s);
		send_text();
	endtask

	// width change only once every bitmap is out and the pipeline has drained
	task automatic set_width(logic wide);
		item_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= wide;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		int chars_this;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed texts, narrow bitmap first
		set_width(1'b0);
		send_string("all");
		// blank padding before the keyword
		send_string(" none");
		// zero range start, end clipped to 32, overflow, commit at end of text
		send_string("0-40");
		set_width(1'b1);
		// reversed range, empty commits, ignored char, repeated dash, saturation
		send_string("5-2,,x-3-7 999");

		// random texts: three idle profiles, width flipping every block
		for (int blk = 0; blk < 6; blk++) begin
			case (blk / 2)
				0: begin
					send_idle_pct = 12;
					recv_idle_pct = 50;
				end
				1: begin
					send_idle_pct = 50;
					recv_idle_pct = 12;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			set_width(blk % 2 == 1);
			chars_this = 0;
			while (chars_this < 100) begin
				make_text();
				chars_this += text_q.size() - ignored_n;
				send_text();
			end
		end

		// drain, then idle on to catch stray beats
		item_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		$display("sent %0d texts in %0d characters under both bitmap widths and three idle profiles",
			texts_sent, chars_sent);
		$display("compared %0d bitmap beats, keyword and out-of-range texts among them",
			bitmaps_seen);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/rltb_pkg.sv
rtl/rltb_kw.sv
rtl/rltb_acc.sv
rtl/range_list_text_to_bitmap_unit.sv
dv/range_list_bitmap_check.sv
dv/tb.sv
